// ===== hw/rtl/size_class_free_list_allocator_macros.svh =====
// assertion helpers for the allocator
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// checked on every rising edge outside reset
`define SCFLA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("allocator assertion failed");
// checked on every rising edge, reset included
`define SCFLA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("allocator assertion failed");
`else
`define SCFLA_ASSERT(label, prop)
`define SCFLA_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== hw/rtl/scfla_pkg.sv =====
package scfla_pkg;

  // fixed field widths
  localparam int ADDR_W    = 13;
  localparam int LIMIT_W   = 14;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 14;

  // arena geometry; one header slot per two payload bytes
  localparam int ARENA_BYTES = 8192;
  localparam int SLOTS       = ARENA_BYTES / 2;
  localparam int SLOT_W      = $clog2(SLOTS);

  // parameter defaults
  localparam int DEF_NUM_BUCKETS  = 8;
  localparam int DEF_HEADER_BYTES = 6;

  // reset values of the configuration registers
  localparam logic [ADDR_W-1:0]  RST_ARENA_START = ADDR_W'(64);
  localparam logic [LIMIT_W-1:0] RST_ARENA_LIMIT = LIMIT_W'(8192);

  // smallest payload handed out
  localparam logic [ADDR_W-1:0] MIN_SIZE = ADDR_W'(2);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_LIMIT = 1'b1;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BUCKET = 2'd1,
    ST_NO_ARENA  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_HEAD,
    S_POP,
    S_HDR,
    S_FREAD,
    S_FCHK,
    S_FPUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_step;
    logic    load_req;
    logic    scan_inc;
    logic    claim;
    logic    link_rd;
    logic    take_head;
    logic    bump;
    logic    pop;
    logic    hdr_write;
    logic    hdr_rd;
    logic    take_code;
    logic    push;
    logic    emit;
    logic    emit_addr;
    status_t emit_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_hit;
    logic scan_last;
    logic head_nz;
    logic no_room;
    logic free_bad;
  } sts_t;

endpackage

// ===== hw/rtl/scfla_ctrl.sv =====
module scfla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               kind,
  input  scfla_pkg::sts_t    sts,
  output scfla_pkg::cmd_t    cmd,
  output logic               busy
);

  scfla_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scfla_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      scfla_pkg::S_CLEAR: begin
        if (sts.clr_last) state_next = scfla_pkg::S_IDLE;
      end
      scfla_pkg::S_IDLE: begin
        if (start) begin
          state_next = (kind == scfla_pkg::KIND_FREE) ? scfla_pkg::S_FREAD
                                                      : scfla_pkg::S_SCAN;
        end
      end
      scfla_pkg::S_SCAN: begin
        if (sts.scan_hit)       state_next = scfla_pkg::S_HEAD;
        else if (sts.scan_last) state_next = scfla_pkg::S_IDLE;
      end
      scfla_pkg::S_HEAD: begin
        if (sts.head_nz)      state_next = scfla_pkg::S_POP;
        else if (sts.no_room) state_next = scfla_pkg::S_IDLE;
        else                  state_next = scfla_pkg::S_HDR;
      end
      scfla_pkg::S_POP:   state_next = scfla_pkg::S_HDR;
      scfla_pkg::S_HDR:   state_next = scfla_pkg::S_IDLE;
      scfla_pkg::S_FREAD: state_next = scfla_pkg::S_FCHK;
      scfla_pkg::S_FCHK: begin
        state_next = sts.free_bad ? scfla_pkg::S_IDLE : scfla_pkg::S_FPUSH;
      end
      scfla_pkg::S_FPUSH: state_next = scfla_pkg::S_IDLE;
      default:            state_next = scfla_pkg::S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.emit_status = scfla_pkg::ST_OK;
    case (state)
      scfla_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      scfla_pkg::S_IDLE:  cmd.load_req = start;
      scfla_pkg::S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.claim = 1'b1;
        end else if (sts.scan_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = scfla_pkg::ST_NO_BUCKET;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      scfla_pkg::S_HEAD: begin
        if (sts.head_nz) begin
          cmd.link_rd   = 1'b1;
          cmd.take_head = 1'b1;
        end else if (sts.no_room) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = scfla_pkg::ST_NO_ARENA;
        end else begin
          cmd.bump = 1'b1;
        end
      end
      scfla_pkg::S_POP: cmd.pop = 1'b1;
      scfla_pkg::S_HDR: begin
        cmd.hdr_write = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_addr = 1'b1;
      end
      scfla_pkg::S_FREAD: cmd.hdr_rd = 1'b1;
      scfla_pkg::S_FCHK: begin
        if (sts.free_bad) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = scfla_pkg::ST_BAD_FREE;
        end else begin
          cmd.take_code = 1'b1;
        end
      end
      scfla_pkg::S_FPUSH: begin
        cmd.push = 1'b1;
        cmd.emit = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state != scfla_pkg::S_IDLE);

endmodule

// ===== hw/rtl/scfla_dpath.sv =====
module scfla_dpath #(
  parameter int NUM_BUCKETS  = scfla_pkg::DEF_NUM_BUCKETS,
  parameter int HEADER_BYTES = scfla_pkg::DEF_HEADER_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [scfla_pkg::ADDR_W-1:0]      size,
  input  logic [scfla_pkg::ADDR_W-1:0]      addr,
  input  logic                              cfg_we,
  input  logic [scfla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scfla_pkg::CFG_W-1:0]       cfg_data,
  input  scfla_pkg::cmd_t                   cmd,
  output scfla_pkg::sts_t                   sts,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [scfla_pkg::ADDR_W-1:0]      addr_out
);

  localparam int ADDR_W  = scfla_pkg::ADDR_W;
  localparam int LIMIT_W = scfla_pkg::LIMIT_W;
  localparam int SLOT_W  = scfla_pkg::SLOT_W;
  localparam int SLOTS   = scfla_pkg::SLOTS;
  localparam int IDX_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CODE_W  = $clog2(NUM_BUCKETS + 1);
  localparam int HDR_W   = CODE_W + 1;
  localparam int TOP_W   = LIMIT_W + 1;

  // configuration and bump pointer
  logic [LIMIT_W-1:0] arena_limit;
  logic [LIMIT_W-1:0] bump_top;

  // bucket table
  logic [ADDR_W-1:0] bucket_size [NUM_BUCKETS];
  logic [ADDR_W-1:0] bucket_head [NUM_BUCKETS];

  // request and working registers
  logic [IDX_W-1:0]  bidx;
  logic [ADDR_W-1:0] req_size;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] payload;
  logic [SLOT_W-1:0] clr_cnt;

  // link and header stores, indexed by payload offset / 2
  logic [ADDR_W-1:0] link_mem [SLOTS];
  logic [HDR_W-1:0]  hdr_mem  [SLOTS];
  logic [ADDR_W-1:0] link_q;
  logic [HDR_W-1:0]  hdr_q;

  logic [ADDR_W-1:0]  cur_size;
  logic [ADDR_W-1:0]  cur_head;
  logic [TOP_W-1:0]   top;
  logic [LIMIT_W-1:0] bound;
  logic [CODE_W-1:0]  hdr_code;
  logic               hdr_odd;
  logic [SLOT_W-1:0]  req_slot;
  logic [SLOT_W-1:0]  pay_slot;
  logic [SLOT_W-1:0]  head_slot;
  logic               hdr_we;
  logic [SLOT_W-1:0]  hdr_wa;
  logic [HDR_W-1:0]   hdr_wd;

  // bucket under the index and bump arithmetic
  always_comb begin
    cur_size = bucket_size[bidx];
    cur_head = bucket_head[bidx];
    top      = TOP_W'(bump_top) + TOP_W'(HEADER_BYTES) + TOP_W'(req_size);
    bound    = (arena_limit < LIMIT_W'(scfla_pkg::ARENA_BYTES)) ?
               arena_limit : LIMIT_W'(scfla_pkg::ARENA_BYTES);
    hdr_code = hdr_q[CODE_W-1:0];
    hdr_odd  = hdr_q[CODE_W];
    req_slot  = req_addr[ADDR_W-1:1];
    pay_slot  = payload[ADDR_W-1:1];
    head_slot = cur_head[ADDR_W-1:1];
  end

  // status toward the controller
  always_comb begin
    sts.clr_last  = (clr_cnt == SLOT_W'(SLOTS - 1));
    sts.scan_hit  = (cur_size == '0) || (cur_size == req_size);
    sts.scan_last = (bidx == IDX_W'(NUM_BUCKETS - 1));
    sts.head_nz   = (cur_head != '0);
    sts.no_room   = (top >= TOP_W'(bound));
    sts.free_bad  = (hdr_code == '0) || (hdr_code > CODE_W'(NUM_BUCKETS)) ||
                    (hdr_odd != req_addr[0]);
  end

  // header store write port: clearing pass, allocate mark, free release
  always_comb begin
    hdr_we = cmd.clr_step | cmd.hdr_write | cmd.push;
    if (cmd.clr_step)       hdr_wa = clr_cnt;
    else if (cmd.hdr_write) hdr_wa = pay_slot;
    else                    hdr_wa = req_slot;
    if (cmd.hdr_write) hdr_wd = {payload[0], CODE_W'(bidx) + CODE_W'(1)};
    else               hdr_wd = '0;
  end

  // control registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_limit <= scfla_pkg::RST_ARENA_LIMIT;
      bump_top    <= LIMIT_W'(scfla_pkg::RST_ARENA_START);
      clr_cnt     <= '0;
      done        <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bucket_size[i] <= '0;
        bucket_head[i] <= '0;
      end
    end else begin
      done <= cmd.emit;
      if (cmd.clr_step) clr_cnt <= clr_cnt + SLOT_W'(1);
      // configuration transfer; a new start reloads the bump pointer
      if (cfg_we && cfg_index == scfla_pkg::REG_ARENA_START) begin
        bump_top    <= LIMIT_W'(cfg_data[ADDR_W-1:0]);
      end
      if (cfg_we && cfg_index == scfla_pkg::REG_ARENA_LIMIT) begin
        arena_limit <= cfg_data[LIMIT_W-1:0];
      end
      if (cmd.bump)  bump_top <= top[LIMIT_W-1:0];
      if (cmd.claim) bucket_size[bidx] <= req_size;
      if (cmd.pop)   bucket_head[bidx] <= link_q;
      if (cmd.push)  bucket_head[bidx] <= req_addr;
    end
  end

  // request capture, bucket index and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_size <= (size < scfla_pkg::MIN_SIZE) ? scfla_pkg::MIN_SIZE : size;
      req_addr <= addr;
    end
    if (cmd.load_req)       bidx <= '0;
    else if (cmd.scan_inc)  bidx <= bidx + IDX_W'(1);
    else if (cmd.take_code) bidx <= IDX_W'(hdr_code - CODE_W'(1));
    if (cmd.take_head)      payload <= cur_head;
    else if (cmd.bump)      payload <= ADDR_W'(bump_top + LIMIT_W'(HEADER_BYTES));
    if (cmd.emit) begin
      status   <= cmd.emit_status;
      addr_out <= cmd.emit_addr ? payload : '0;
    end
  end

  // link store: pushed on free, read on pop
  always_ff @(posedge clk) begin
    if (cmd.push)    link_mem[req_slot] <= cur_head;
    if (cmd.link_rd) link_q <= link_mem[head_slot];
  end

  // header store
  always_ff @(posedge clk) begin
    if (hdr_we)     hdr_mem[hdr_wa] <= hdr_wd;
    if (cmd.hdr_rd) hdr_q <= hdr_mem[req_slot];
  end

endmodule

// ===== hw/rtl/size_class_free_list_allocator.sv =====
// Segregated free-list allocator over one arena.
// Requests: present kind/size/addr with start high; a request is taken at a
// rising edge where start is high and busy is low. kind 0 allocates size
// bytes, kind 1 frees the payload offset on addr.
// Results: done is high for exactly one cycle with status and addr_out; the
// receiver cannot hold results off, so they must be taken when shown.
// Sequence: an allocate scans the bucket table one bucket per cycle, up to
// NUM_BUCKETS buckets, then checks the head or bumps, reads the free-list
// link when popping, and writes the header; done is registered from the
// header-write state. Failures end earlier. A free reads the header, checks
// it and pushes. busy drops in the cycle done is shown, so the next request
// can be taken then. An allocate takes longer the further its bucket lies.
// Reset: the header store is cleared by a pass over all 4096 entries, one
// entry per cycle, with busy high; configuration writes are taken during it.
// Configuration: cfg_we with cfg_index 0 writes arena_start (and reloads
// the bump pointer), index 1 writes arena_limit; write only while idle.
`include "size_class_free_list_allocator_macros.svh"

module size_class_free_list_allocator #(
  parameter int NUM_BUCKETS  = scfla_pkg::DEF_NUM_BUCKETS,
  parameter int HEADER_BYTES = scfla_pkg::DEF_HEADER_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [scfla_pkg::ADDR_W-1:0]      size,
  input  logic [scfla_pkg::ADDR_W-1:0]      addr,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [scfla_pkg::ADDR_W-1:0]      addr_out,
  input  logic                              cfg_we,
  input  logic [scfla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scfla_pkg::CFG_W-1:0]       cfg_data
);

  scfla_pkg::cmd_t cmd;
  scfla_pkg::sts_t sts;

  // sequencer
  scfla_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // bucket table, bump pointer and stores
  scfla_dpath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .size      (size),
    .addr      (addr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .status    (status),
    .addr_out  (addr_out)
  );

  // done is never high in two consecutive cycles
  `SCFLA_ASSERT(a_done_single, done |=> !done)
  // an accepted request keeps the block busy in the next cycle
  `SCFLA_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  // failed requests never return an offset
  `SCFLA_ASSERT(a_fail_no_addr, (done && status != scfla_pkg::ST_OK) |-> addr_out == '0)
  // the clearing pass follows reset
  `SCFLA_ASSERT_ALWAYS(a_clear_after_rst, rst |=> busy)

endmodule
